FILE: hdl/trie_longest_prefix_match_assert.svh
// Assertion macros shared by the trie longest-prefix-match RTL.
`ifndef TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH
`define TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property every clock edge, disabled while reset is high.
`define TLPM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Check a property every clock edge, reset included.
`define TLPM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define TLPM_ASSERT(lbl, clk, rst, prop)
`define TLPM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hdl/tlpm_pkg.sv
// Types and constants of the trie longest-prefix-match block.
package tlpm_pkg;

  // Pool and key geometry
  localparam int MAX_NODES  = 1024;
  localparam int MAX_DIGITS = 10;
  localparam int ALPHABET   = 11;

  localparam int DIGIT_W = 4;
  localparam int KEY_W   = MAX_DIGITS * DIGIT_W;
  localparam int LEN_W   = 4;
  localparam int OP_W    = 2;
  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int NEXT_W  = $clog2(MAX_NODES + 1);
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int DIDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int SLOT_W  = $clog2(ALPHABET);

  // Configuration port
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_KEY_LENGTH = 2'd0;
  localparam logic [LEN_W-1:0]      KEY_LENGTH_RESET = 4'd10;

  // One pool row holds the child links of one node
  typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FRESH,
    S_DONE
  } state_t;

endpackage

FILE: hdl/tlpm_req_if.sv
// Request channel: operation and key with a valid/ready handshake.
interface tlpm_req_if import tlpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] key;

  modport source (output valid, operation, key, input ready);
  modport sink   (input valid, operation, key, output ready);
endinterface

FILE: hdl/tlpm_rsp_if.sv
// Response channel: match length and overflow flag with a valid/ready handshake.
interface tlpm_rsp_if import tlpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] match_length;
  logic             overflow;

  modport source (output valid, match_length, overflow, input ready);
  modport sink   (input valid, match_length, overflow, output ready);
endinterface

FILE: hdl/tlpm_cfg.sv
// APB register file holding the key length register.
module tlpm_cfg import tlpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [LEN_W-1:0]      key_length
);

  logic wr_key_length;

  assign pready        = 1'b1;
  assign wr_key_length = psel && penable && pwrite && (paddr == ADDR_KEY_LENGTH);

  // Capture the register on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LENGTH_RESET;
    end else if (wr_key_length) begin
      key_length <= pwdata[LEN_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_KEY_LENGTH) begin
      prdata = {{(APB_DATA_W - LEN_W){1'b0}}, key_length};
    end
  end

endmodule

FILE: hdl/trie_longest_prefix_match.sv
// Trie longest-prefix match over a node pool held in one row-wide memory.
// Clear and ignored operations go from idle through done to the output register; insert and
// query first walk the pool rows in the walk state and write fresh nodes in the fresh state.
// One item at a time: a new request is accepted only in idle, once the result is registered.
// Reset (synchronous): the trie is empty and key_length is 10; no clearing pass is needed,
// since rows are written whole when their node is allocated.
`include "trie_longest_prefix_match_assert.svh"

module trie_longest_prefix_match import tlpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tlpm_req_if.sink              req,
  tlpm_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration
  logic [LEN_W-1:0] key_length;

  tlpm_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_length (key_length)
  );

  // Node pool
  row_t              mem [MAX_NODES];
  row_t              rd_data;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  row_t              wr_data;

  // Control and working registers
  state_t                   state, state_next;
  logic [OP_W-1:0]          op_r, op_next;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] key_r, key_next;
  logic [CNT_W-1:0]         len_r, len_next;
  logic [CNT_W-1:0]         idx, idx_next;
  logic [NODE_W-1:0]        cur, cur_next;
  logic [NEXT_W-1:0]        nf, nf_next;
  logic                     ovf, ovf_next;
  logic                     out_valid, out_valid_next;
  logic [LEN_W-1:0]         out_len, out_len_next;
  logic                     out_ovf, out_ovf_next;

  // Decode helpers
  logic [CNT_W-1:0]  eff_len;
  logic              start_walk;
  logic [DIGIT_W-1:0] digit;
  logic              in_alpha;
  logic [SLOT_W-1:0] slot;
  row_t              row_now;
  logic [NODE_W-1:0] child;
  logic              pool_full;
  logic              last_digit;
  logic              at_end;
  logic              out_free;
  logic              walk_done;
  logic              walk_alloc;
  logic              fresh_done;

  // Saturate the configured length
  always_comb begin
    if ({1'b0, key_length} > (LEN_W + 1)'(MAX_DIGITS)) begin
      eff_len = CNT_W'(MAX_DIGITS);
    end else begin
      eff_len = CNT_W'(key_length);
    end
  end

  assign start_walk = ((req.operation == OP_INSERT) || (req.operation == OP_QUERY)) &&
                      (eff_len != '0);

  // Current digit, child link and pool status
  always_comb begin
    if (idx < CNT_W'(MAX_DIGITS)) begin
      digit = key_r[idx[DIDX_W-1:0]];
    end else begin
      digit = '0;
    end
  end

  assign in_alpha   = ({1'b0, digit} < (DIGIT_W + 1)'(ALPHABET));
  assign slot       = in_alpha ? digit[SLOT_W-1:0] : '0;
  assign row_now    = (nf == NEXT_W'(1)) ? '0 : rd_data;
  assign child      = row_now[slot];
  assign pool_full  = (nf >= NEXT_W'(MAX_NODES));
  assign at_end     = (idx == len_r);
  assign last_digit = ((idx + CNT_W'(1)) == len_r);
  assign out_free   = !out_valid || rsp.ready;

  // Walk and allocation decisions
  always_comb begin
    walk_done  = 1'b0;
    walk_alloc = 1'b0;
    if (!in_alpha) begin
      walk_done = 1'b1;
    end else if (child != '0) begin
      walk_done = last_digit;
    end else if ((op_r == OP_QUERY) || pool_full) begin
      walk_done = 1'b1;
    end else begin
      walk_alloc = 1'b1;
    end
  end

  assign fresh_done = at_end || !in_alpha || pool_full;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = start_walk ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_next = S_DONE;
        end else if (walk_alloc) begin
          state_next = S_FRESH;
        end
      end
      S_FRESH: begin
        if (fresh_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result
  always_comb begin
    op_next        = op_r;
    key_next       = key_r;
    len_next       = len_r;
    idx_next       = idx;
    cur_next       = cur;
    nf_next        = nf;
    ovf_next       = ovf;
    out_valid_next = out_valid && !rsp.ready;
    out_len_next   = out_len;
    out_ovf_next   = out_ovf;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = cur;
    wr_data        = '0;
    req.ready      = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          op_next  = req.operation;
          key_next = req.key;
          len_next = eff_len;
          idx_next = '0;
          cur_next = '0;
          ovf_next = 1'b0;
          if (req.operation == OP_CLEAR) begin
            nf_next = NEXT_W'(1);
          end
          // Fetch the root row
          rd_en = start_walk;
        end
      end
      S_WALK: begin
        if (in_alpha && (child != '0)) begin
          // Follow an existing link
          cur_next = child;
          idx_next = idx + CNT_W'(1);
          rd_en    = !last_digit;
          rd_addr  = child;
        end else if (in_alpha && (op_r == OP_INSERT)) begin
          if (pool_full) begin
            ovf_next = 1'b1;
          end else begin
            // Link a fresh node into the existing row
            wr_en         = 1'b1;
            wr_data       = row_now;
            wr_data[slot] = nf[NODE_W-1:0];
            cur_next      = nf[NODE_W-1:0];
            nf_next       = nf + NEXT_W'(1);
            idx_next      = idx + CNT_W'(1);
          end
        end
      end
      S_FRESH: begin
        // A fresh node's row is written whole: empty, or one link to the next fresh node
        wr_en = 1'b1;
        if (fresh_done) begin
          ovf_next = !at_end && in_alpha && pool_full;
        end else begin
          wr_data[slot] = nf[NODE_W-1:0];
          cur_next      = nf[NODE_W-1:0];
          nf_next       = nf + NEXT_W'(1);
          idx_next      = idx + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_len_next   = (op_r == OP_QUERY) ? LEN_W'(idx) : '0;
          out_ovf_next   = ovf;
        end
      end
      default: begin
      end
    endcase
  end

  // Pool memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      nf        <= NEXT_W'(1);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      nf        <= nf_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_next;
    key_r   <= key_next;
    len_r   <= len_next;
    idx     <= idx_next;
    cur     <= cur_next;
    ovf     <= ovf_next;
    out_len <= out_len_next;
    out_ovf <= out_ovf_next;
  end

  assign rsp.valid        = out_valid;
  assign rsp.match_length = out_len;
  assign rsp.overflow     = out_ovf;

  // Checks
  `TLPM_ASSERT(a_pool_count, clk, rst, (nf >= NEXT_W'(1)) && (nf <= NEXT_W'(MAX_NODES)))
  `TLPM_ASSERT(a_read_walks, clk, rst, rd_en |=> (state == S_WALK))
  `TLPM_ASSERT(a_write_state, clk, rst, wr_en |-> ((state == S_WALK) || (state == S_FRESH)))
  `TLPM_ASSERT(a_fresh_last, clk, rst, (state == S_FRESH) |-> (({1'b0, cur} + NEXT_W'(1)) == nf))
  `TLPM_ASSERT(a_idx_bound, clk, rst, ((state == S_WALK) || (state == S_FRESH)) |-> (idx <= len_r))

endmodule
